/* sv/ntc_pkg.sv */
// ----------------------------------------------------------------------------
// ntc_pkg: shared constants and the log table for the NTC temperature block
// Holds the field widths, the ln(1+i/32) table and the sequencer handshake type.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int unsigned SamplesAveraged = 15;
    localparam int unsigned AdcBits         = 12;
    localparam int unsigned Ln2Q16          = 45426;
    localparam int unsigned KelvinOffsetCk  = 27315;

    localparam logic [11:0] AdcFullScale = 12'hFFF;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DIVIDER  = 2'd0;
    localparam logic [1:0] REG_NOMINAL  = 2'd1;
    localparam logic [1:0] REG_NOM_TEMP = 2'd2;
    localparam logic [1:0] REG_BETA     = 2'd3;

    // Natural-log mantissa table, Q16, ln(1 + i/32)
    function automatic logic [15:0] ln_tab(input logic [5:0] idx);
        logic [15:0] v;
        case (idx)
            6'd0:  v = 16'd0;     6'd1:  v = 16'd2017;  6'd2:  v = 16'd3973;
            6'd3:  v = 16'd5873;  6'd4:  v = 16'd7719;  6'd5:  v = 16'd9515;
            6'd6:  v = 16'd11262; 6'd7:  v = 16'd12965; 6'd8:  v = 16'd14624;
            6'd9:  v = 16'd16242; 6'd10: v = 16'd17821; 6'd11: v = 16'd19364;
            6'd12: v = 16'd20870; 6'd13: v = 16'd22343; 6'd14: v = 16'd23783;
            6'd15: v = 16'd25193; 6'd16: v = 16'd26573; 6'd17: v = 16'd27924;
            6'd18: v = 16'd29248; 6'd19: v = 16'd30546; 6'd20: v = 16'd31818;
            6'd21: v = 16'd33067; 6'd22: v = 16'd34292; 6'd23: v = 16'd35494;
            6'd24: v = 16'd36675; 6'd25: v = 16'd37835; 6'd26: v = 16'd38975;
            6'd27: v = 16'd40095; 6'd28: v = 16'd41196; 6'd29: v = 16'd42280;
            6'd30: v = 16'd43345; 6'd31: v = 16'd44394; 6'd32: v = 16'd45426;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // Start / done handshake between the top level and the arithmetic engine
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } ntc_ctl_t;

endpackage

/* sv/ntc_engine.sv */
// ----------------------------------------------------------------------------
// ntc_engine: average to temperature, bit-serial arithmetic
// Divides the sum by the sample count, takes four Q16 logs, multiplies
// bit-serially and runs a restoring divide one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ntc_engine import ntc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [15:0]       sum_in,
    input  logic [19:0]       r_div,
    input  logic [19:0]       r_nom,
    input  logic [15:0]       t_nom,
    input  logic [14:0]       beta,
    output ntc_ctl_t          ctl,
    output logic signed [15:0] temp_out,
    output logic              ok_out,
    output logic [11:0]       avg_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_AVG, S_CHECK, S_LN, S_MUL_B, S_MUL_L, S_MUL_N, S_MUL_N2,
        S_DIV, S_FIN
    } state_t;

    state_t      state_reg;
    logic [4:0]  cnt_reg;
    logic [15:0] rem_reg;       // average division remainder
    logic [11:0] avg_reg;
    logic [1:0]  ln_sel_reg;
    logic [5:0]  ln_k_reg;      // bit search step
    logic [19:0] ln_x_reg;
    logic signed [25:0] l_reg;  // ln(R/R0), Q16
    logic [22:0] b100_reg;      // beta*100 built from shifts
    logic [63:0] acc_reg;       // multiply accumulator
    logic [63:0] mcand_reg;     // shifted multiplicand
    logic [25:0] mplier_reg;    // multiplier shifted out one bit a cycle
    logic        msign_reg;
    logic signed [47:0] den_reg;
    logic [63:0] num_reg;
    logic [63:0] qrem_reg;
    logic [63:0] quo_reg;
    logic [6:0]  qcnt_reg;
    logic signed [15:0] temp_reg;
    logic        ok_reg;
    logic        done_reg;

    // Log of the operand currently selected, on narrow logic
    logic [19:0] ln_x;
    logic [4:0]  ln_k;
    logic [15:0] ln_frac;
    logic [15:0] ln_lo, ln_hi;
    logic [26:0] ln_mix;
    logic [21:0] ln_val;
    logic [16:0] avg_rem_try;
    logic [64:0] q_try;

    always_comb begin
        ln_x = ln_x_reg;
        ln_k = ln_k_reg[4:0];
        if (ln_k <= 5'd16) begin
            ln_frac = 16'(ln_x << (5'd16 - ln_k));
        end else begin
            ln_frac = 16'(ln_x >> (ln_k - 5'd16));
        end
        ln_lo  = ln_tab({1'b0, ln_frac[15:11]});
        ln_hi  = ln_tab({1'b0, ln_frac[15:11]} + 6'd1);
        ln_mix = 27'((ln_hi - ln_lo) * ln_frac[10:0]) + 27'd1024;
        ln_val = 22'(ln_k) * 22'(Ln2Q16) + 22'(ln_lo) + 22'(ln_mix[26:11]);
        avg_rem_try = {rem_reg, sum_in[15 - cnt_reg[3:0]]} - 17'(SamplesAveraged);
        q_try = {qrem_reg, num_reg[63]} - {{17{den_reg[47]}}, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        state_reg <= S_AVG;
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        avg_reg   <= '0;
                    end
                end
                // Long division of the sum by the sample count, one bit a cycle
                S_AVG: begin
                    if (!avg_rem_try[16]) begin
                        rem_reg <= avg_rem_try[15:0];
                        avg_reg <= {avg_reg[10:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[14:0], sum_in[15 - cnt_reg[3:0]]};
                        avg_reg <= {avg_reg[10:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15) begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (avg_reg == '0 || r_nom == '0) begin
                        temp_reg <= -16'(KelvinOffsetCk);
                        ok_reg   <= 1'b0;
                        state_reg <= S_FIN;
                    end else if (avg_reg == AdcFullScale || r_div == '0) begin
                        temp_reg <= 16'sd32767;
                        ok_reg   <= 1'b0;
                        state_reg <= S_FIN;
                    end else begin
                        ln_sel_reg <= 2'd0;
                        ln_x_reg   <= r_div;
                        ln_k_reg   <= 6'd0;
                        l_reg      <= '0;
                        state_reg  <= S_LN;
                    end
                end
                // Find the top set bit one step a cycle, then add or subtract its log
                S_LN: begin
                    if (ln_k_reg < 6'd19 && (ln_x_reg >> (ln_k_reg + 6'd1)) != '0) begin
                        ln_k_reg <= ln_k_reg + 6'd1;
                    end else begin
                        if (ln_sel_reg[1] == ln_sel_reg[0]) begin
                            l_reg <= (ln_sel_reg == 2'd0) ? l_reg + 26'(ln_val)
                                                         : l_reg - 26'(ln_val);
                        end else begin
                            l_reg <= (ln_sel_reg == 2'd1) ? l_reg + 26'(ln_val)
                                                         : l_reg - 26'(ln_val);
                        end
                        ln_k_reg   <= 6'd0;
                        ln_sel_reg <= ln_sel_reg + 2'd1;
                        case (ln_sel_reg)
                            2'd0: ln_x_reg <= 20'(AdcFullScale - avg_reg);
                            2'd1: ln_x_reg <= 20'(avg_reg);
                            2'd2: ln_x_reg <= r_nom;
                            default: ln_x_reg <= '0;
                        endcase
                        if (ln_sel_reg == 2'd3) begin
                            b100_reg  <= 23'({beta, 6'd0}) + 23'({beta, 5'd0})
                                       + 23'({beta, 2'd0});
                            state_reg <= S_MUL_B;
                        end
                    end
                end
                // den = b100*2^16 + L*T0 ; L*T0 by shift and add
                S_MUL_B: begin
                    acc_reg    <= '0;
                    mcand_reg  <= 64'(t_nom);
                    msign_reg  <= l_reg[25];
                    mplier_reg <= l_reg[25] ? 26'(-l_reg) : 26'(l_reg);
                    cnt_reg    <= '0;
                    state_reg  <= S_MUL_L;
                end
                S_MUL_L: begin
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[62:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[25:1]};
                    cnt_reg    <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd25) begin
                        state_reg <= S_MUL_N;
                    end
                end
                S_MUL_N: begin
                    den_reg <= (msign_reg ? -$signed(48'(acc_reg)) : $signed(48'(acc_reg)))
                             + $signed({9'd0, b100_reg, 16'd0});
                    acc_reg    <= '0;
                    mcand_reg  <= {25'd0, b100_reg, 16'd0};
                    mplier_reg <= 26'(t_nom);
                    cnt_reg    <= '0;
                    state_reg  <= S_MUL_N2;
                end
                // num = b100*2^16*T0 + den/2, the half divisor rounding the quotient
                S_MUL_N2: begin
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[62:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[25:1]};
                    cnt_reg    <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd15) begin
                        if (den_reg <= 48'sd0) begin
                            temp_reg  <= 16'sd32767;
                            ok_reg    <= 1'b0;
                            state_reg <= S_FIN;
                        end else begin
                            num_reg   <= (mplier_reg[0] ? acc_reg + mcand_reg : acc_reg)
                                       + 64'(den_reg[47:1]);
                            qrem_reg  <= '0;
                            quo_reg   <= '0;
                            qcnt_reg  <= '0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                // Restoring divide, one quotient bit per cycle
                S_DIV: begin
                    if (!q_try[64]) begin
                        qrem_reg <= q_try[63:0];
                        quo_reg  <= {quo_reg[62:0], 1'b1};
                    end else begin
                        qrem_reg <= {qrem_reg[62:0], num_reg[63]};
                        quo_reg  <= {quo_reg[62:0], 1'b0};
                    end
                    num_reg  <= {num_reg[62:0], 1'b0};
                    qcnt_reg <= qcnt_reg + 7'd1;
                    if (qcnt_reg == 7'd63) begin
                        state_reg <= S_FIN;
                        ok_reg    <= 1'b1;
                        temp_reg  <= '0;
                    end
                end
                S_FIN: begin
                    if (ok_reg) begin
                        if (quo_reg > 64'(32767 + KelvinOffsetCk)) begin
                            temp_reg <= 16'sd32767;
                            ok_reg   <= 1'b0;
                        end else begin
                            temp_reg <= 16'(quo_reg[16:0] - 17'(KelvinOffsetCk));
                        end
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign ctl.start = start;
    assign ctl.busy  = (state_reg != S_IDLE);
    assign ctl.done  = done_reg;
    assign temp_out  = temp_reg;
    assign ok_out    = ok_reg;
    assign avg_out   = avg_reg;

    // A result is flagged only after a pass through the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(state_reg) == S_FIN) else $error("done without finish");
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg && ok_reg |-> avg_reg != '0 && avg_reg != AdcFullScale)
        else $error("in range with saturated average");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_AVG |=> $stable(sum_in)) else $error("sum changed during divide");

endmodule

/* sv/ntc_temperature_average_convert.sv */
// ----------------------------------------------------------------------------
// ntc_temperature_average_convert: averaged NTC divider reading to temperature
// Sums samples and on every fifteenth one converts the average to 0.01 degC.
// ----------------------------------------------------------------------------
// Samples 1..14 of a group: added to the sum back to back, no result.
// Fifteenth sample: the engine runs 16 average-divide steps, n = 4..64 log search
// steps, 42 multiply steps and 64 divide steps, then the result is registered at the output.
// Input is held from the fifteenth sample until the result transfers and the engine
// is idle; s_ready then rises again once wait_reg clears.
// Synchronous active-low reset clears the sum, count and flags and loads config defaults.
module ntc_temperature_average_convert import ntc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_adc_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_temp_centi_c,
    output logic               m_in_range,
    output logic [11:0]        m_adc_average,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [19:0]        cfg_wdata
);

    logic [19:0] r_div_reg, r_nom_reg;
    logic [15:0] t_nom_reg;
    logic [14:0] beta_reg;
    logic [15:0] sum_reg, sum_next;
    logic [3:0]  count_reg;
    logic [15:0] hold_reg;
    logic        go_reg;
    logic        wait_reg;
    ntc_ctl_t    ctl;
    logic signed [15:0] e_temp;
    logic        e_ok;
    logic [11:0] e_avg;

    assign sum_next = sum_reg + 16'(s_adc_sample);
    assign s_ready  = !wait_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_div_reg <= 20'd10000;
            r_nom_reg <= 20'd10000;
            t_nom_reg <= 16'd29815;
            beta_reg  <= 15'd3950;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DIVIDER:  r_div_reg <= cfg_wdata;
                REG_NOMINAL:  r_nom_reg <= cfg_wdata;
                REG_NOM_TEMP: t_nom_reg <= cfg_wdata[15:0];
                REG_BETA:     beta_reg  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Accumulation and launch; output register waits for its transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
            go_reg    <= 1'b0;
            wait_reg  <= 1'b0;
            m_valid   <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            if (s_valid && s_ready) begin
                if (count_reg == 4'(SamplesAveraged - 1)) begin
                    hold_reg  <= sum_next;
                    sum_reg   <= '0;
                    count_reg <= '0;
                    go_reg    <= 1'b1;
                    wait_reg  <= 1'b1;
                end else begin
                    sum_reg   <= sum_next;
                    count_reg <= count_reg + 4'd1;
                end
            end
            if (ctl.done) begin
                m_temp_centi_c <= e_temp;
                m_in_range     <= e_ok;
                m_adc_average  <= e_avg;
                m_valid        <= 1'b1;
            end
            if (wait_reg && !go_reg && !ctl.busy && !ctl.done && !m_valid) begin
                wait_reg <= 1'b0;
            end
        end
    end

    ntc_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (go_reg),
        .sum_in   (hold_reg),
        .r_div    (r_div_reg),
        .r_nom    (r_nom_reg),
        .t_nom    (t_nom_reg),
        .beta     (beta_reg),
        .ctl      (ctl),
        .temp_out (e_temp),
        .ok_out   (e_ok),
        .avg_out  (e_avg)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.done |-> wait_reg) else $error("result without pending group");
    assert property (@(posedge aclk) disable iff (!aresetn)
        go_reg |-> !ctl.busy) else $error("launch while engine busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.done |-> !m_valid) else $error("output overwritten");

endmodule
